// ===== sv/priority_request_arbiter_table_unit_macros.svh =====
// Assertion macros used by the top level of the arbiter table RTL.
`ifndef PRIORITY_REQUEST_ARBITER_TABLE_UNIT_MACROS_SVH
`define PRIORITY_REQUEST_ARBITER_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk and idle while aresetn is low.
`define PRAT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and idle while aresetn is low.
`define PRAT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/prat_pkg.sv =====
// Types and constants of the priority request arbiter table.
`timescale 1ns / 1ps
package prat_pkg;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 72;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    // One stored request.
    typedef struct packed {
        logic [15:0] id;
        logic [15:0] tag;
        logic [15:0] prio;
        logic [15:0] inten;
        logic [15:0] reason;
    } slot_entry_t;

    typedef struct packed {
        logic clr;
        logic upd;
    } best_ctl_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] tag;
        logic [15:0] inten;
        logic [15:0] reason;
    } best_t;

endpackage

// ===== sv/prat_best_track.sv =====
// Running winner of a resolve pass over the stored requests.
`timescale 1ns / 1ps
module prat_best_track import prat_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  best_ctl_t   ctl,
    input  slot_entry_t cand,
    output best_t       best
);

    logic        best_vld_reg;
    logic        best_vld_next;
    slot_entry_t best_reg;
    slot_entry_t best_next;
    logic        take;

    // Strictly better only, so the earliest entry keeps a full tie.
    assign take = !best_vld_reg
               || ($signed(cand.prio) > $signed(best_reg.prio))
               || ((cand.prio == best_reg.prio) && (cand.inten > best_reg.inten));

    always_comb begin
        best_vld_next = best_vld_reg;
        best_next     = best_reg;
        if (ctl.clr) begin
            best_vld_next = 1'b0;
        end else if (ctl.upd && take) begin
            best_vld_next = 1'b1;
            best_next     = cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_vld_reg <= 1'b0;
        end else begin
            best_vld_reg <= best_vld_next;
        end
        best_reg <= best_next;
    end

    assign best.valid  = best_vld_reg;
    assign best.tag    = best_reg.tag;
    assign best.inten  = best_reg.inten;
    assign best.reason = best_reg.reason;

endmodule

// ===== sv/priority_request_arbiter_table_unit.sv =====
// Top level of the priority request arbiter table.
//
// Channel  Dir  Payload (lowest bit first)
// s_       in   opcode 2, state_tag 16, priority_req 16, intensity 18,
//               reason_code 16, request_id 16, zero pad 4
// m_       out  status 3, assigned_id 16, changed 1, resolved_tag 16,
//               resolved_intensity 16, resolved_reason 16, zero pad 4
//
// Requests live in one slot memory with a registered read; entries fill a prefix
// of it and a fill count marks its end. A submit, clear or unused opcode runs a
// resolve pass, one read per entry present after the request. A remove first runs
// a compaction read-write pass over the old entries, then the resolve pass.
// s_tready is high only in idle. A finished result waits in the output register
// while the next request is taken. Reset is synchronous on aresetn and empties
// the table at once.
`timescale 1ns / 1ps
module priority_request_arbiter_table_unit import prat_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode, state_tag, priority_req, intensity, reason_code, request_id
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status, assigned_id, changed, resolved_tag, resolved_intensity, resolved_reason
    output logic [OUT_TDATA_W-1:0] m_tdata
);

`include "priority_request_arbiter_table_unit_macros.svh"

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_COMPACT = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_FINISH  = 4'b1000
    } fsm_state_t;

    fsm_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic                   pend_reg, pend_next;
    logic                   hit_reg, hit_next;
    logic [15:0]            rid_reg, rid_next;
    logic [2:0]             status_reg, status_next;
    logic [15:0]            assigned_reg, assigned_next;
    logic                   changed_reg, changed_next;
    logic [15:0]            next_id_reg, next_id_next;
    logic [15:0]            cur_tag_reg, cur_tag_next;
    logic [15:0]            cur_inten_reg, cur_inten_next;
    logic [15:0]            cur_reason_reg, cur_reason_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    slot_entry_t            mem [SLOTS];
    slot_entry_t            rd_data_reg;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa;
    slot_entry_t            mem_wd;
    logic                   mem_re;
    logic [IDX_W-1:0]       mem_ra;

    logic [1:0]             in_op;
    logic [15:0]            in_tag;
    logic [15:0]            in_prio;
    logic [17:0]            in_inten;
    logic [15:0]            in_reason;
    logic [15:0]            in_rid;
    logic [15:0]            in_inten_clamped;
    logic                   accept;
    logic                   scan_more;
    best_ctl_t              best_ctl;
    best_t                  best;
    logic [15:0]            win_tag;
    logic [15:0]            win_inten;
    logic [15:0]            win_reason;
    logic                   win_changed;

    assign in_op     = s_tdata[1:0];
    assign in_tag    = s_tdata[17:2];
    assign in_prio   = s_tdata[33:18];
    assign in_inten  = s_tdata[51:34];
    assign in_reason = s_tdata[67:52];
    assign in_rid    = s_tdata[83:68];

    assign in_inten_clamped = in_inten[17] ? 16'd0 :
                              (in_inten[16] ? 16'hFFFF : in_inten[15:0]);

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign scan_more = (rd_ptr_reg < cnt_reg);
    assign mem_re    = ((state_reg == S_COMPACT) || (state_reg == S_RESOLVE)) && scan_more;
    assign mem_ra    = rd_ptr_reg[IDX_W-1:0];

    assign win_tag     = best.valid ? best.tag : 16'd0;
    assign win_inten   = best.valid ? best.inten : 16'd0;
    assign win_reason  = best.valid ? best.reason : 16'd0;
    assign win_changed = (win_tag != cur_tag_reg) || (win_inten != cur_inten_reg);

    // The compaction pass writes slot w only after slot w has been read, and reads
    // run ahead of writes, so the read and write ports never meet on one slot.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    prat_best_track u_best (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (best_ctl),
        .cand    (rd_data_reg),
        .best    (best)
    );

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        pend_next       = pend_reg;
        hit_next        = hit_reg;
        rid_next        = rid_reg;
        status_next     = status_reg;
        assigned_next   = assigned_reg;
        changed_next    = changed_reg;
        next_id_next    = next_id_reg;
        cur_tag_next    = cur_tag_reg;
        cur_inten_next  = cur_inten_reg;
        cur_reason_next = cur_reason_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_wa          = cnt_reg[IDX_W-1:0];
        mem_wd.id       = next_id_reg;
        mem_wd.tag      = in_tag;
        mem_wd.prio     = in_prio;
        mem_wd.inten    = in_inten_clamped;
        mem_wd.reason   = in_reason;
        best_ctl.clr    = 1'b0;
        best_ctl.upd    = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    rd_ptr_next   = '0;
                    wr_ptr_next   = '0;
                    pend_next     = 1'b0;
                    hit_next      = 1'b0;
                    rid_next      = in_rid;
                    assigned_next = 16'd0;
                    best_ctl.clr  = 1'b1;
                    state_next    = S_RESOLVE;
                    case (in_op)
                        OP_SUBMIT: begin
                            if (in_tag == 16'd0) begin
                                status_next = ST_INVALID;
                            end else if (cnt_reg == FULL_CNT) begin
                                status_next = ST_FULL;
                            end else begin
                                mem_we        = 1'b1;
                                cnt_next      = cnt_reg + 1'b1;
                                assigned_next = next_id_reg;
                                next_id_next  = (next_id_reg == 16'hFFFF) ? 16'd1
                                                                          : next_id_reg + 16'd1;
                                status_next   = ST_ACCEPTED;
                            end
                        end
                        OP_REMOVE: begin
                            state_next = S_COMPACT;
                        end
                        OP_CLEAR: begin
                            cnt_next    = '0;
                            status_next = ST_CLEARED;
                        end
                        default: begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_COMPACT: begin
                pend_next = scan_more;
                if (scan_more) begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (rd_data_reg.id == rid_reg) begin
                        hit_next = 1'b1;
                    end else begin
                        mem_we      = 1'b1;
                        mem_wa      = wr_ptr_reg[IDX_W-1:0];
                        mem_wd      = rd_data_reg;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                end
                if (!scan_more && !pend_reg) begin
                    cnt_next     = wr_ptr_reg;
                    status_next  = hit_reg ? ST_REMOVED : ST_NOT_FOUND;
                    rd_ptr_next  = '0;
                    best_ctl.clr = 1'b1;
                    state_next   = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                pend_next    = scan_more;
                best_ctl.upd = pend_reg;
                if (scan_more) begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                if (!scan_more && !pend_reg) begin
                    changed_next = win_changed;
                    if (win_changed) begin
                        cur_tag_next    = win_tag;
                        cur_inten_next  = win_inten;
                        cur_reason_next = win_reason;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, cur_reason_reg, cur_inten_reg, cur_tag_reg,
                                     changed_reg, assigned_reg, status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            pend_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            next_id_reg    <= 16'd1;
            cur_tag_reg    <= 16'd0;
            cur_inten_reg  <= 16'd0;
            cur_reason_reg <= 16'd0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            pend_reg       <= pend_next;
            hit_reg        <= hit_next;
            next_id_reg    <= next_id_next;
            cur_tag_reg    <= cur_tag_next;
            cur_inten_reg  <= cur_inten_next;
            cur_reason_reg <= cur_reason_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        rid_reg      <= rid_next;
        status_reg   <= status_next;
        assigned_reg <= assigned_next;
        changed_reg  <= changed_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PRAT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= FULL_CNT, "fill count beyond table size")
    `PRAT_ASSERT_SAME(a_wr_behind_rd, state_reg == S_COMPACT, wr_ptr_reg <= rd_ptr_reg, "compaction write pointer passed read pointer")
    `PRAT_ASSERT_NEXT(a_submit_grows, accept && (in_op == OP_SUBMIT) && (in_tag != 16'd0) && (cnt_reg != FULL_CNT), cnt_reg == $past(cnt_reg) + 1'b1, "accepted submit did not grow the table")
    `PRAT_ASSERT_SAME(a_winner_tag, (state_reg == S_FINISH) && (cnt_reg != '0), cur_tag_reg != 16'd0, "non-empty table resolved to tag zero")

endmodule

// ===== verif/priority_request_arbiter_table_unit_test.sv =====
// Self-checking testbench for the priority request arbiter table unit.
`timescale 1ns / 1ps
module priority_request_arbiter_table_unit_test;
    import prat_pkg::*;

    localparam int SLOTS = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;

    // Field order matches the stream payload: the last member sits in the lowest bits.
    typedef struct packed {
        logic [15:0] rid;
        logic [15:0] reason;
        logic [17:0] inten;
        logic [15:0] prio;
        logic [15:0] tag;
        logic [1:0]  op;
    } request_t;

    typedef struct packed {
        logic [15:0] reason;
        logic [15:0] inten;
        logic [15:0] tag;
        logic        changed;
        logic [15:0] id;
        logic [2:0]  status;
    } verdict_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // opcode, state_tag, priority_req, intensity, reason, id
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // status, assigned_id, changed, tag, intensity, reason

    priority_request_arbiter_table_unit #(.SLOTS(SLOTS)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Shadow of the arbiter table.
    logic [15:0]        tbl_id    [SLOTS];
    logic [15:0]        tbl_tag   [SLOTS];
    logic signed [15:0] tbl_prio  [SLOTS];
    logic [15:0]        tbl_inten [SLOTS];
    logic [15:0]        tbl_reason[SLOTS];
    int                 tbl_count = 0;
    logic [15:0]        issue_id = 16'd1;
    logic [15:0]        win_tag = '0;
    logic [15:0]        win_inten = '0;
    logic [15:0]        win_reason = '0;

    request_t request_backlog[$];
    verdict_t pending_verdicts[$];
    request_t cur_req;
    // A request is on the bus while more have been put there than were taken.
    int       sent_count = 0;
    int       taken_count = 0;

    // Live ids as the stimulus generator sees them, used to aim removes.
    logic [15:0] gen_ids[$];
    logic [15:0] gen_next = 16'd1;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic flag_mismatch(string what, longint got, longint want);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_field(string what, longint got, longint want);
        if (got != want)
            flag_mismatch(what, got, want);
    endtask

    function automatic verdict_t arbitrate_request(request_t r);
        verdict_t    v;
        int          ival;
        int          w;
        int          best;
        logic        hit;
        logic [15:0] btag;
        logic [15:0] binten;
        logic [15:0] breason;
        v = '0;
        v.status = ST_NOT_FOUND;
        case (r.op)
            OP_SUBMIT: begin
                if (r.tag == 16'd0) begin
                    v.status = ST_INVALID;
                end else if (tbl_count >= SLOTS) begin
                    v.status = ST_FULL;
                end else begin
                    ival = int'($signed(r.inten));
                    if (ival < 0)
                        ival = 0;
                    else if (ival > 65535)
                        ival = 65535;
                    tbl_id[tbl_count] = issue_id;
                    tbl_tag[tbl_count] = r.tag;
                    tbl_prio[tbl_count] = r.prio;
                    tbl_inten[tbl_count] = ival[15:0];
                    tbl_reason[tbl_count] = r.reason;
                    tbl_count++;
                    v.id = issue_id;
                    issue_id = (issue_id == 16'hFFFF) ? 16'd1 : issue_id + 16'd1;
                    v.status = ST_ACCEPTED;
                end
            end
            OP_REMOVE: begin
                w = 0;
                hit = 1'b0;
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_id[i] == r.rid) begin
                        hit = 1'b1;
                    end else begin
                        tbl_id[w] = tbl_id[i];
                        tbl_tag[w] = tbl_tag[i];
                        tbl_prio[w] = tbl_prio[i];
                        tbl_inten[w] = tbl_inten[i];
                        tbl_reason[w] = tbl_reason[i];
                        w++;
                    end
                end
                tbl_count = w;
                v.status = hit ? ST_REMOVED : ST_NOT_FOUND;
            end
            OP_CLEAR: begin
                tbl_count = 0;
                v.status = ST_CLEARED;
            end
            default: ;
        endcase

        // Highest priority, then highest intensity; the earliest entry keeps a full tie.
        best = -1;
        for (int i = 0; i < tbl_count; i++) begin
            if (best < 0 || tbl_prio[i] > tbl_prio[best] ||
                (tbl_prio[i] == tbl_prio[best] && tbl_inten[i] > tbl_inten[best]))
                best = i;
        end
        btag = '0;
        binten = '0;
        breason = '0;
        if (best >= 0) begin
            btag = tbl_tag[best];
            binten = tbl_inten[best];
            breason = tbl_reason[best];
        end
        if (btag != win_tag || binten != win_inten) begin
            win_tag = btag;
            win_inten = binten;
            win_reason = breason;
            v.changed = 1'b1;
        end
        v.tag = win_tag;
        v.inten = win_inten;
        v.reason = win_reason;
        return v;
    endfunction

    task automatic push_request(logic [1:0] op, logic [15:0] tag, int prio, int inten,
                                logic [15:0] reason, logic [15:0] rid);
        request_t r;
        r.op = op;
        r.tag = tag;
        r.prio = prio[15:0];
        r.inten = inten[17:0];
        r.reason = reason;
        r.rid = rid;
        request_backlog.push_back(r);
        case (op)
            OP_SUBMIT: begin
                if (tag != 16'd0 && gen_ids.size() < SLOTS) begin
                    gen_ids.push_back(gen_next);
                    gen_next = (gen_next == 16'hFFFF) ? 16'd1 : gen_next + 16'd1;
                end
            end
            OP_REMOVE: begin
                for (int i = gen_ids.size() - 1; i >= 0; i--)
                    if (gen_ids[i] == rid)
                        gen_ids.delete(i);
            end
            OP_CLEAR: gen_ids.delete();
            default: ;
        endcase
    endtask

    task automatic make_random_requests(int n);
        int          pick;
        logic [1:0]  op;
        logic [15:0] tag;
        logic [15:0] rid;
        int          prio;
        int          inten;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                op = OP_SUBMIT;
            else if (pick < 85)
                op = OP_REMOVE;
            else if (pick < 95)
                op = OP_CLEAR;
            else
                op = OP_UNUSED;

            // Few tags, priorities and intensities so that ties and unchanged winners occur.
            pick = $urandom_range(0, 99);
            if (pick < 8)
                tag = 16'd0;
            else if (pick < 50)
                tag = 16'($urandom_range(1, 4));
            else
                tag = 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 1) == 0)
                prio = $urandom_range(0, 4) - 2;
            else
                prio = $urandom_range(0, 65535);
            pick = $urandom_range(0, 99);
            if (pick < 15)
                inten = 0;
            else if (pick < 30)
                inten = 65535;
            else if (pick < 40)
                inten = 1000;
            else
                inten = $urandom_range(0, 196607) - 65536;

            if (op == OP_REMOVE && gen_ids.size() != 0 && $urandom_range(0, 99) < 80)
                rid = gen_ids[$urandom_range(0, gen_ids.size() - 1)];
            else
                rid = 16'($urandom_range(0, 65535));
            push_request(op, tag, prio, inten, 16'($urandom_range(0, 65535)), rid);
        end
    endtask

    task automatic wait_idle();
        while (request_backlog.size() != 0 || sent_count != taken_count ||
               pending_verdicts.size() != 0)
            @(posedge aclk);
    endtask

    // Request side and result-side backpressure, both driven on the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            m_tready <= 1'b0;
        end else begin
            if (sent_count == taken_count && request_backlog.size() != 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                cur_req = request_backlog.pop_front();
                sent_count++;
                s_tdata <= {4'b0, cur_req};
            end
            s_tvalid <= (sent_count != taken_count);
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin : watch_channels
        verdict_t got;
        verdict_t want;
        logic     moved;
        if (aresetn) begin
            moved = 1'b0;
            if (s_tvalid && s_tready) begin
                pending_verdicts.push_back(arbitrate_request(cur_req));
                taken_count++;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                moved = 1'b1;
                got = verdict_t'(m_tdata[$bits(verdict_t)-1:0]);
                if (pending_verdicts.size() == 0) begin
                    flag_mismatch("result without request", longint'(got.status), longint'(0));
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("status", longint'(got.status), longint'(want.status));
                    check_field("assigned_id", longint'(got.id), longint'(want.id));
                    check_field("changed", longint'(got.changed), longint'(want.changed));
                    check_field("resolved_tag", longint'(got.tag), longint'(want.tag));
                    check_field("resolved_intensity", longint'(got.inten),
                                longint'(want.inten));
                    check_field("resolved_reason", longint'(got.reason),
                                longint'(want.reason));
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        int          send_mix[4];
        int          recv_mix[4];
        send_mix = '{0, 72, 0, 10};
        recv_mix = '{0, 0, 72, 10};
        aresetn = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed opening: empty table, unused opcode, bad tag, clamps and ties.
        push_request(OP_CLEAR, 16'd0, 0, 0, 16'd0, 16'd0);
        push_request(OP_UNUSED, 16'hFFFF, -1, -1, 16'hFFFF, 16'hFFFF);
        push_request(OP_SUBMIT, 16'd0, 32767, 65535, 16'h1234, 16'd0);
        push_request(OP_SUBMIT, 16'hFFFF, -32768, -65536, 16'hFFFF, 16'd0);
        push_request(OP_SUBMIT, 16'd1, 32767, 131071, 16'h0011, 16'hFFFF);
        push_request(OP_SUBMIT, 16'd1, 32767, 65535, 16'h0022, 16'd0);
        push_request(OP_SUBMIT, 16'd2, 32767, 65536, 16'h0033, 16'd0);
        push_request(OP_SUBMIT, 16'd3, 0, -1, 16'h0044, 16'd0);
        push_request(OP_SUBMIT, 16'd4, 5, 0, 16'h0055, 16'd0);
        for (int i = 0; i < 10; i++)
            push_request(OP_SUBMIT, 16'h0010 + 16'(i), i - 3, i * 4000, 16'(i), 16'd0);
        push_request(OP_SUBMIT, 16'h0BAD, 32767, 65535, 16'h0066, 16'd0);
        // The first tie loser takes over with the same tag and intensity: reason is kept.
        push_request(OP_REMOVE, 16'd0, 0, 0, 16'd0, 16'd2);
        push_request(OP_REMOVE, 16'd0, 0, 0, 16'd0, 16'd3);
        push_request(OP_REMOVE, 16'd0, 0, 0, 16'd0, 16'hFFFF);
        push_request(OP_REMOVE, 16'd0, 0, 0, 16'd0, 16'd0);
        push_request(OP_CLEAR, 16'd0, 0, 0, 16'd0, 16'd0);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = send_mix[p];
            recv_stall_pct = recv_mix[p];
            make_random_requests(200);
            wait_idle();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        repeat (60) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== priority_request_arbiter_table_unit.f =====
+incdir+sv
sv/prat_pkg.sv
sv/prat_best_track.sv
sv/priority_request_arbiter_table_unit.sv
verif/priority_request_arbiter_table_unit_test.sv
